@@ rtl/dla_pkg.sv @@
package dla_pkg;

    // Accumulator width, Q24.16 signed
    localparam int ACC_W = 40;

    // Input operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // Sequencer to MAC unit control
    typedef struct packed {
        logic issue;   // weight read data valid this cycle
        logic clear;   // zero all row sums
    } t_mac_ctl;

    // MAC unit status back to sequencer
    typedef struct packed {
        logic busy;    // product in flight
    } t_mac_sts;

endpackage

@@ rtl/dla_if.sv @@
interface dla_in_if #(
    parameter int IDX_W  = 7,
    parameter int DATA_W = 16
) ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [IDX_W-1:0]         weight_index;
    logic signed [DATA_W-1:0] weight_value;
    logic signed [DATA_W-1:0] feature_value;
    logic                     last_feature;

    modport source (
        output valid, operation, weight_index, weight_value, feature_value, last_feature,
        input  ready
    );
    modport sink (
        input  valid, operation, weight_index, weight_value, feature_value, last_feature,
        output ready
    );
endinterface

interface dla_out_if #(
    parameter int CHOICE_W = 2,
    parameter int SCORE_W  = 40
) ();
    logic                      valid;
    logic                      ready;
    logic [CHOICE_W-1:0]       choice;
    logic signed [SCORE_W-1:0] best_score;

    modport source (output valid, choice, best_score, input ready);
    modport sink   (input valid, choice, best_score, output ready);
endinterface

@@ rtl/dla_wmem.sv @@
module dla_wmem #(
    parameter int  DEPTH  = 96,
    parameter int  DATA_W = 16,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/dla_mac.sv @@
module dla_mac #(
    parameter int  DATA_W = 16,
    parameter int  ROWS   = 4,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int ACC_W  = dla_pkg::ACC_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dla_pkg::t_mac_ctl        i_ctl,
    input  logic [ROW_W-1:0]         i_row,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_feature,
    input  logic [ROW_W-1:0]         i_scan_row,
    output logic signed [ACC_W-1:0]  o_sum,
    output dla_pkg::t_mac_sts        o_sts
);

    localparam int PW = 2 * DATA_W;
    localparam int EW = (PW > ACC_W) ? PW : ACC_W;

    logic signed [PW-1:0]    r_prod;
    logic [ROW_W-1:0]        r_prow;
    logic                    r_pvalid;
    logic signed [ACC_W-1:0] r_sum [ROWS];

    logic [ROW_W-1:0]        rd_row;
    logic signed [EW-1:0]    prod_ext;

    // single read port: accumulate has priority, scan otherwise
    assign rd_row   = r_pvalid ? r_prow : i_scan_row;
    assign o_sum    = r_sum[rd_row];
    assign prod_ext = EW'(r_prod);
    assign o_sts.busy = r_pvalid;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_weight * i_feature;
        r_prow <= i_row;
    end

    // accumulate stage, wraps modulo 2^ACC_W
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < ROWS; k++) begin
                r_sum[k] <= '0;
            end
        end else if (r_pvalid) begin
            r_sum[r_prow] <= o_sum + prod_ext[ACC_W-1:0];
        end
    end

endmodule

@@ rtl/dense_layer_argmax.sv @@
// Channel   Dir  Payload                                             Notes
// i_in      in   operation, weight_index, weight_value,              weight write or feature
//                feature_value, last_feature
// o_out     out  choice, best_score                                  one per last feature
//
// Weight write: written in the accept cycle at the single weight write port.
// Feature: one weight read and one multiply per row through the shared MAC unit, so
//   the weight read port sets the rate.
// Last feature: then pipeline drain, an argmax scan over every row, and emit.
// Reset is synchronous, active low; weight store is not cleared (undefined until written).
// A pending result in the output register does not block input; a new result waits in
//   the emit state until the output register is free.
module dense_layer_argmax #(
    parameter int NUM_FEATURES = 24,
    parameter int NUM_CHOICES  = 4,
    parameter int DATA_WIDTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dla_in_if.sink    i_in,
    dla_out_if.source o_out
);

    localparam int DEPTH = NUM_CHOICES * NUM_FEATURES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ROW_W = $clog2(NUM_CHOICES);
    localparam int CNT_W = $clog2(NUM_FEATURES + 1);
    localparam int ACC_W = dla_pkg::ACC_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // take requests
    localparam logic [1:0] S_FEAT = 2'd1;   // one weight read per row
    localparam logic [1:0] S_SCAN = 2'd2;   // argmax, one row per cycle once no product is in flight
    localparam logic [1:0] S_EMIT = 2'd3;   // load output register, clear sums

    logic [1:0]                   r_state, n_state;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [IDX_W-1:0]             r_addr, n_addr;
    logic [CNT_W-1:0]             r_count, n_count;
    logic signed [DATA_WIDTH-1:0] r_feat, n_feat;
    logic                         r_last, n_last;
    logic                         r_rd_valid;
    logic [ROW_W-1:0]             r_rd_row;
    logic [ROW_W-1:0]             r_best_idx, n_best_idx;
    logic signed [ACC_W-1:0]      r_best, n_best;
    logic                         r_out_valid, n_out_valid;
    logic [ROW_W-1:0]             r_choice, n_choice;
    logic signed [ACC_W-1:0]      r_score, n_score;

    logic                         accept;
    logic                         wr_en;
    logic                         rd_en;
    logic                         last_row;
    logic                         out_free;
    logic                         busy;
    logic                         better;
    logic signed [DATA_WIDTH-1:0] rd_weight;
    logic signed [ACC_W-1:0]      sum;
    dla_pkg::t_mac_ctl            mac_ctl;
    dla_pkg::t_mac_sts            mac_sts;

    assign i_in.ready       = (r_state == S_IDLE);
    assign accept           = i_in.valid && i_in.ready;
    // out-of-range writes dropped
    assign wr_en            = accept && (i_in.operation == dla_pkg::OP_WRITE)
                              && ({1'b0, i_in.weight_index} < (IDX_W + 1)'(DEPTH));
    assign rd_en            = (r_state == S_FEAT);
    assign last_row         = (r_row == ROW_W'(NUM_CHOICES - 1));
    assign out_free         = !r_out_valid || o_out.ready;
    assign busy             = r_rd_valid || mac_sts.busy;
    assign better           = (sum > r_best);

    assign o_out.valid      = r_out_valid;
    assign o_out.choice     = r_choice;
    assign o_out.best_score = r_score;

    dla_wmem #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_WIDTH)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_in.weight_index),
        .i_wdata (i_in.weight_value),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_weight)
    );

    dla_mac #(
        .DATA_W (DATA_WIDTH),
        .ROWS   (NUM_CHOICES)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_row      (r_rd_row),
        .i_weight   (rd_weight),
        .i_feature  (r_feat),
        .i_scan_row (r_row),
        .o_sum      (sum),
        .o_sts      (mac_sts)
    );

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_addr        = r_addr;
        n_count       = r_count;
        n_feat        = r_feat;
        n_last        = r_last;
        n_best_idx    = r_best_idx;
        n_best        = r_best;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_choice      = r_choice;
        n_score       = r_score;
        mac_ctl.issue = r_rd_valid;
        mac_ctl.clear = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in.operation == dla_pkg::OP_FEATURE)) begin
                    n_feat = i_in.feature_value;
                    n_last = i_in.last_feature;
                    n_row  = '0;
                    if (r_count < CNT_W'(NUM_FEATURES)) begin
                        // column base, rows follow at stride NUM_FEATURES
                        n_addr  = IDX_W'(r_count);
                        n_state = S_FEAT;
                    end else if (i_in.last_feature) begin
                        // saturated: no accumulate, still report
                        n_state = S_SCAN;
                    end
                end
            end
            S_FEAT: begin
                n_addr = r_addr + IDX_W'(NUM_FEATURES);
                n_row  = r_row + ROW_W'(1);
                if (last_row) begin
                    n_row   = '0;
                    n_count = r_count + CNT_W'(1);
                    n_state = r_last ? S_SCAN : S_IDLE;
                end
            end
            S_SCAN: begin
                // wait for in-flight products to land
                if (!busy) begin
                    // strict greater keeps lowest row on ties
                    if ((r_row == '0) || better) begin
                        n_best     = sum;
                        n_best_idx = r_row;
                    end
                    if (last_row) begin
                        n_row   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_choice      = r_best_idx;
                    n_score       = r_best;
                    n_count       = '0;
                    mac_ctl.clear = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_count     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_count     <= n_count;
            r_rd_valid  <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_feat     <= n_feat;
        r_last     <= n_last;
        r_rd_row   <= r_row;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_choice   <= n_choice;
        r_score    <= n_score;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_FEATURES))
        else $error("feature count beyond NUM_FEATURES");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEAT && last_row) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("feature count not advanced after last row");

    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_count == '0 && r_state == S_IDLE
                                            && r_out_valid))
        else $error("emit did not clear and present result");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result presented outside emit");

endmodule

@@ bench/tb_dense_layer_argmax.sv @@
`timescale 1ns / 1ps

module tb_dense_layer_argmax;

    // Sizes match the block's default parameters
    localparam int N_FEAT   = 24;
    localparam int N_ROWS   = 4;
    localparam int N_WEIGHT = N_FEAT * N_ROWS;

    localparam int   ACC_W      = dla_pkg::ACC_W;
    localparam logic OP_WRITE   = dla_pkg::OP_WRITE;
    localparam logic OP_FEATURE = dla_pkg::OP_FEATURE;

    localparam int N_ITEMS     = 550;      // random part stops past this many requests
    localparam int N_VECTORS   = 16;       // ...and past this many feature vectors
    localparam int RX_HOLD     = 300;      // long output back-pressure, in cycles
    localparam int DRAIN_WAIT  = 20;       // settle time after the last result
    localparam int CYCLE_LIMIT = 400000;

    // One input request and one argmax result
    typedef struct packed {
        logic                    op;
        logic [6:0]              idx;
        logic signed [15:0]      wval;
        logic signed [15:0]      fval;
        logic                    last;
    } layer_req_t;

    typedef struct packed {
        logic [1:0]              choice;
        logic signed [ACC_W-1:0] score;
    } pick_t;

    // Directed row: request plus an optional hand-computed result
    typedef struct {
        layer_req_t req;
        bit         typed;
        pick_t      pick;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dla_in_if  in_if ();
    dla_out_if out_if ();

    dense_layer_argmax dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Layer predictor: weight store, four row sums, feature count
    // ------------------------------------------------------------------
    logic signed [15:0]      weight_mem [N_WEIGHT];
    logic signed [ACC_W-1:0] row_sum [N_ROWS];
    int unsigned             feat_cnt;

    pick_t    pick_q[$];        // argmax results still owed by the block
    dir_row_t dir_tab[$];

    int  n_items;
    int  n_errors;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  rx_hold_req;
    int  cycle_cnt;

    // Applies one request to the predictor; returns 1 when it yields a result
    function automatic bit infer_layer(input layer_req_t rq, output pick_t pk);
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] best_v;
        logic [1:0]              best_r;
        pk = '0;
        if (rq.op == OP_WRITE) begin
            // indexes past the store are dropped; last flag is don't-care
            if (rq.idx < N_WEIGHT)
                weight_mem[rq.idx] = rq.wval;
            return 1'b0;
        end
        // features past the vector length are ignored, count saturates
        if (feat_cnt < N_FEAT) begin
            for (int r = 0; r < N_ROWS; r++) begin
                prod       = weight_mem[r * N_FEAT + feat_cnt] * rq.fval;
                row_sum[r] = row_sum[r] + prod;
            end
            feat_cnt++;
        end
        if (!rq.last)
            return 1'b0;
        // strict compare keeps the lowest row on a tie
        best_r = 2'd0;
        best_v = row_sum[0];
        for (int r = 1; r < N_ROWS; r++) begin
            if (row_sum[r] > best_v) begin
                best_v = row_sum[r];
                best_r = 2'(r);
            end
        end
        pk.choice = best_r;
        pk.score  = best_v;
        foreach (row_sum[r])
            row_sum[r] = '0;
        feat_cnt = 0;
        return 1'b1;
    endfunction

    // Sample with extra weight on the corners of the Q8.8 range
    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(19))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Don't-care fields are randomized so their bits still toggle
    function automatic layer_req_t wr(input logic [6:0] idx, input logic signed [15:0] val);
        layer_req_t rq;
        rq.op   = OP_WRITE;
        rq.idx  = idx;
        rq.wval = val;
        rq.fval = 16'($urandom);
        rq.last = 1'($urandom);
        return rq;
    endfunction

    function automatic layer_req_t ft(input logic signed [15:0] val, input logic last);
        layer_req_t rq;
        rq.op   = OP_FEATURE;
        rq.idx  = 7'($urandom);
        rq.wval = 16'($urandom);
        rq.fval = val;
        rq.last = last;
        return rq;
    endfunction

    function automatic void add_row(input layer_req_t rq, input bit typed,
                                    input logic [1:0] choice, input longint score);
        dir_row_t row;
        row.req          = rq;
        row.typed        = typed;
        row.pick.choice  = choice;
        row.pick.score   = ACC_W'(score);
        dir_tab.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: drive at negedge, accept at posedge
    // ------------------------------------------------------------------
    task automatic send_req(input layer_req_t rq, input bit typed, input pick_t typed_pick);
        pick_t pk;
        // random sender gaps; each gap advances to the next negedge
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= rq.op;
        in_if.weight_index  <= rq.idx;
        in_if.weight_value  <= rq.wval;
        in_if.feature_value <= rq.fval;
        in_if.last_feature  <= rq.last;
        do @(posedge clk); while (!in_if.ready);
        n_items++;
        if (infer_layer(rq, pk))
            pick_q.push_back(typed ? typed_pick : pk);
        @(negedge clk);
    endtask

    // Sender holds off until every owed result has been taken
    task automatic pause_until_drained();
        in_if.valid <= 1'b0;
        do @(negedge clk); while (pick_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        hold         = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold        = RX_HOLD;
            end
            if (hold != 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Compare every accepted result against the oldest expectation
    always @(posedge clk) begin
        pick_t exp_pk;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pick_q.size() == 0) begin
                $display("%0t: unexpected result, got choice %0d score %0d",
                         $time, out_if.choice, out_if.best_score);
                n_errors++;
            end else begin
                exp_pk = pick_q.pop_front();
                if (out_if.choice !== exp_pk.choice) begin
                    $display("%0t: choice mismatch, expected %0d, got %0d",
                             $time, exp_pk.choice, out_if.choice);
                    n_errors++;
                end
                if (out_if.best_score !== exp_pk.score) begin
                    $display("%0t: best_score mismatch, expected %0d, got %0d",
                             $time, exp_pk.score, out_if.best_score);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int vec_no;
        int len;
        int sel;
        int cur_phase;
        int new_phase;
        bit hold_done;
        logic signed [15:0] fill;

        cycle_cnt           = 0;
        n_items             = 0;
        n_errors            = 0;
        tx_idle_pct         = 0;
        rx_stall_pct        = 0;
        rx_hold_req         = 1'b0;
        feat_cnt            = 0;
        foreach (row_sum[r])
            row_sum[r] = '0;
        foreach (weight_mem[i])
            weight_mem[i] = '0;

        rst_n               = 1'b0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_WRITE;
        in_if.weight_index  = '0;
        in_if.weight_value  = '0;
        in_if.feature_value = '0;
        in_if.last_feature  = 1'b0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load the whole store first: no feature may read an unwritten weight
        for (int k = 0; k < N_WEIGHT; k++)
            send_req(wr(7'(k), rand_sample()), 1'b0, '0);

        // Directed part. Column 0 weights: row0 -32768, row1 32767, row2 0, row3 32767
        add_row(wr(7'd0,  -16'sd32768), 0, 0, 0);
        add_row(wr(7'd24,  16'sd32767), 0, 0, 0);
        add_row(wr(7'd48,  16'sd0),     0, 0, 0);
        add_row(wr(7'd72,  16'sd32767), 0, 0, 0);
        // most negative feature times most negative weight wins
        add_row(ft(-16'sd32768, 1'b1), 1, 2'd0, 64'sd1073741824);
        // all sums zero: four-way tie goes to row 0
        add_row(ft(16'sd0, 1'b1),      1, 2'd0, 64'sd0);
        // rows 1 and 3 tie, lower one wins
        add_row(ft(16'sd32767, 1'b1),  1, 2'd1, 64'sd1073676289);
        // writes past the store are dropped
        add_row(wr(7'd96,  16'sh7fff),  0, 0, 0);
        add_row(wr(7'd127, -16'sd1),    0, 0, 0);
        // write with last flag set gives no result
        add_row('{op: OP_WRITE, idx: 7'd48, wval: 16'sd32767, fval: -16'sd1, last: 1'b1},
                0, 0, 0);
        // rows 1..3 tie three ways
        add_row(ft(16'sd32767, 1'b1),  1, 2'd1, 64'sd1073676289);
        add_row(wr(7'd72, -16'sd32768), 0, 0, 0);
        // rows 0 and 3 tie at the top
        add_row(ft(-16'sd32768, 1'b1), 1, 2'd0, 64'sd1073741824);
        add_row(ft(16'sd1, 1'b1),      1, 2'd1, 64'sd32767);
        // column 1 and a two-feature vector
        add_row(wr(7'd1,   16'sh0100),  0, 0, 0);
        add_row(wr(7'd25, -16'sd1),     0, 0, 0);
        add_row(wr(7'd49,  16'sd32767), 0, 0, 0);
        add_row(wr(7'd73, -16'sd32768), 0, 0, 0);
        add_row(ft(16'sd256, 1'b0),    0, 0, 0);
        add_row(ft(-16'sd1, 1'b1),     0, 0, 0);
        // short vector with mixed-sign sums
        add_row(ft(-16'sd4096, 1'b0),  0, 0, 0);
        add_row(ft(16'sd12345, 1'b1),  0, 0, 0);

        tx_idle_pct  = 8;
        rx_stall_pct = 8;
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].pick);
        pause_until_drained();

        // Random part: idling phase rotates every four vectors
        vec_no    = 0;
        cur_phase = -1;
        hold_done = 1'b0;
        while (n_items < N_ITEMS || vec_no < N_VECTORS) begin
            new_phase = (vec_no / 4) % 4;
            if (new_phase != cur_phase) begin
                pause_until_drained();
                cur_phase = new_phase;
                case (cur_phase)
                    0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1:       begin tx_idle_pct = 67; rx_stall_pct = 0;  end
                    2:       begin tx_idle_pct = 0;  rx_stall_pct = 67; end
                    default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
                endcase
            end

            // Output held off while one-feature vectors pile up behind it
            if (vec_no == 10 && !hold_done) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
                repeat (8) send_req(ft(rand_sample(), 1'b1), 1'b0, '0);
                pause_until_drained();
            end

            sel = $urandom_range(99);
            if (sel < 4) begin
                // whole store at one extreme, pushes the sums to their limits
                fill = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
                for (int k = 0; k < N_WEIGHT; k++)
                    send_req(wr(7'(k), fill), 1'b0, '0);
            end else if (sel < 20) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(9) == 0)
                        send_req(wr(7'($urandom_range(N_WEIGHT, 127)), rand_sample()),
                                 1'b0, '0);
                    else
                        send_req(wr(7'($urandom_range(N_WEIGHT - 1)), rand_sample()),
                                 1'b0, '0);
                end
            end else begin
                // full vectors mostly; short and overlong ones too
                sel = $urandom_range(99);
                if (sel < 50)
                    len = N_FEAT;
                else if (sel < 75)
                    len = $urandom_range(1, N_FEAT - 1);
                else if (sel < 90)
                    len = $urandom_range(N_FEAT + 1, N_FEAT + 6);
                else
                    len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    send_req(ft(rand_sample(), k == len - 1), 1'b0, '0);
                vec_no++;
            end
        end

        pause_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0 && pick_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/dla_pkg.sv
rtl/dla_if.sv
rtl/dla_wmem.sv
rtl/dla_mac.sv
rtl/dense_layer_argmax.sv
bench/tb_dense_layer_argmax.sv
